// ===== hw/rtl/ebfc_pkg.sv =====
// Shared constants, coefficient table and microprogram for the ECG biquad chain.
`default_nettype none

package ebfc_pkg;

  // Default configuration
  localparam int SECTION_COUNT_DEF  = 4;
  localparam int COEF_FRAC_BITS_DEF = 30;
  localparam int STATE_WIDTH_DEF    = 48;

  // Field and format widths
  localparam int RAW_W          = 12;
  localparam int MV_W           = 12;
  localparam int OUT_W          = 22;
  localparam int COEF_W         = 32;
  localparam int MUL_W          = 33;
  localparam int PROD_W         = 2 * MUL_W;
  localparam int HALF_W         = 32;
  localparam int OPND_EXT_W     = 64;
  localparam int ACC_GUARD      = 36;
  localparam int SAMPLE_FRAC    = 16;
  localparam int OUT_FRAC_DROP  = 8;
  localparam int TABLE_FRAC     = 30;
  localparam int TABLE_SECTIONS = 8;
  localparam int TBL_IDX_W      = 3;
  localparam int STEP_W         = 4;

  // Millivolt scaling: floor(raw * 3100 / 4095)
  localparam int MV_PROD_W = 24;
  localparam logic [MV_PROD_W-1:0] MV_SCALE = 24'd3100;
  localparam logic [MV_W:0] DIV_ONE = 13'd4095;
  localparam logic [MV_W:0] DIV_TWO = 13'd8190;

  // Microprogram steps with a fixed meaning
  localparam logic [STEP_W-1:0] STEP_FIRST  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_FINISH = 4'd13;

  typedef enum logic [2:0] {
    ACC_HOLD    = 3'd0,
    ACC_LOAD_S1 = 3'd1,
    ACC_LOAD_S2 = 3'd2,
    ACC_SET     = 3'd3,
    ACC_ADD     = 3'd4,
    ACC_SUB     = 3'd5
  } acc_op_t;

  typedef enum logic [2:0] {
    COEF_B0 = 3'd0,
    COEF_B1 = 3'd1,
    COEF_B2 = 3'd2,
    COEF_A1 = 3'd3,
    COEF_A2 = 3'd4
  } coef_sel_t;

  typedef enum logic {
    OPND_X = 1'b0,
    OPND_Y = 1'b1
  } opnd_t;

  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_Y    = 2'd1,
    WR_S1   = 2'd2,
    WR_S2   = 2'd3
  } wr_t;

  typedef enum logic [1:0] {
    SEQ_NEXT    = 2'd0,
    SEQ_SECTION = 2'd1,
    SEQ_FINISH  = 2'd2
  } seq_t;

  typedef struct packed {
    acc_op_t   acc;
    logic      mul_en;
    coef_sel_t coef;
    opnd_t     opnd;
    logic      hi;
    wr_t       wr;
    seq_t      seq;
  } uword_t;

  // b0, b1, b2, a1, a2 in signed Q2.30; spare sections pass through
  localparam logic signed [COEF_W-1:0] COEF_TABLE [TABLE_SECTIONS][5] = '{
    '{ 32'sd1064243069, -32'sd2128486138, 32'sd1064243069,
      -32'sd2128402107,  32'sd1054828346 },
    '{ 32'sd1063325044, -32'sd1720496063, 32'sd1063325044,
      -32'sd1720496063,  32'sd1052908265 },
    '{ 32'sd1061629567, -32'sd1547789296, 32'sd1061629567,
      -32'sd1547789296,  32'sd1049517309 },
    '{ 32'sd21564350,    32'sd43128699,   32'sd21564350,
      -32'sd1676130396,  32'sd688645970 },
    '{ 32'sd1073741824, 32'sd0, 32'sd0, 32'sd0, 32'sd0 },
    '{ 32'sd1073741824, 32'sd0, 32'sd0, 32'sd0, 32'sd0 },
    '{ 32'sd1073741824, 32'sd0, 32'sd0, 32'sd0, 32'sd0 },
    '{ 32'sd1073741824, 32'sd0, 32'sd0, 32'sd0, 32'sd0 }
  };

  // Coefficient at reduced precision, rounded toward minus infinity
  function automatic logic signed [COEF_W-1:0] coef_lookup(
    input logic [TBL_IDX_W-1:0] sec,
    input coef_sel_t            k,
    input int                   drop
  );
    logic signed [COEF_W-1:0] c;
    unique case (k)
      COEF_B0: c = COEF_TABLE[sec][0];
      COEF_B1: c = COEF_TABLE[sec][1];
      COEF_B2: c = COEF_TABLE[sec][2];
      COEF_A1: c = COEF_TABLE[sec][3];
      COEF_A2: c = COEF_TABLE[sec][4];
      default: c = '0;
    endcase
    return c >>> drop;
  endfunction

  // One section: multiplies issue in one step, the accumulator takes the
  // product in the next step.
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    unique case (step)
      4'd0:  w = '{ACC_LOAD_S1, 1'b1, COEF_B0, OPND_X, 1'b0, WR_NONE, SEQ_NEXT};
      4'd1:  w = '{ACC_ADD,     1'b1, COEF_B0, OPND_X, 1'b1, WR_NONE, SEQ_NEXT};
      4'd2:  w = '{ACC_ADD,     1'b0, COEF_B0, OPND_X, 1'b0, WR_NONE, SEQ_NEXT};
      4'd3:  w = '{ACC_LOAD_S2, 1'b1, COEF_B1, OPND_X, 1'b0, WR_Y,    SEQ_NEXT};
      4'd4:  w = '{ACC_ADD,     1'b1, COEF_B1, OPND_X, 1'b1, WR_NONE, SEQ_NEXT};
      4'd5:  w = '{ACC_ADD,     1'b1, COEF_A1, OPND_Y, 1'b0, WR_NONE, SEQ_NEXT};
      4'd6:  w = '{ACC_SUB,     1'b1, COEF_A1, OPND_Y, 1'b1, WR_NONE, SEQ_NEXT};
      4'd7:  w = '{ACC_SUB,     1'b1, COEF_B2, OPND_X, 1'b0, WR_NONE, SEQ_NEXT};
      4'd8:  w = '{ACC_SET,     1'b1, COEF_B2, OPND_X, 1'b1, WR_S1,   SEQ_NEXT};
      4'd9:  w = '{ACC_ADD,     1'b1, COEF_A2, OPND_Y, 1'b0, WR_NONE, SEQ_NEXT};
      4'd10: w = '{ACC_SUB,     1'b1, COEF_A2, OPND_Y, 1'b1, WR_NONE, SEQ_NEXT};
      4'd11: w = '{ACC_SUB,     1'b0, COEF_B0, OPND_X, 1'b0, WR_NONE, SEQ_NEXT};
      4'd12: w = '{ACC_HOLD,    1'b0, COEF_B0, OPND_X, 1'b0, WR_S2,   SEQ_SECTION};
      default: w = '{ACC_HOLD,  1'b0, COEF_B0, OPND_X, 1'b0, WR_NONE, SEQ_FINISH};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ecg_biquad_filter_chain_unit.sv =====
// ECG sample conditioning: millivolt scaling, lead-off flag, cascaded biquads.
//
//  channel | ports                                              | dir
//  --------+----------------------------------------------------+-----
//  in      | in_valid, in_stall, in_raw_sample,                 | in
//          | in_lead_off_plus, in_lead_off_minus                |
//  out     | out_req_valid, out_stall, out_millivolts,          | out
//          | out_lead_detached, out_filtered_value              |
//
// A request is worked through in order: its acceptance, 13 microprogram
// steps per section on the single shared 33x33 multiplier, and one finish
// step that loads the output register.
// Reset clears the sequencer, the output valid and all section delay state.
// in_stall stays high while a request is being filtered; a stalled result
// sits in the output register while the next request is already accepted,
// and only the finish step waits on it.
`default_nettype none

module ecg_biquad_filter_chain_unit #(
  parameter int SECTION_COUNT  = ebfc_pkg::SECTION_COUNT_DEF,
  parameter int COEF_FRAC_BITS = ebfc_pkg::COEF_FRAC_BITS_DEF,
  parameter int STATE_WIDTH    = ebfc_pkg::STATE_WIDTH_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire  [ebfc_pkg::RAW_W-1:0]          in_raw_sample,
  input  wire                                 in_lead_off_plus,
  input  wire                                 in_lead_off_minus,
  output logic                                out_req_valid,
  input  wire                                 out_stall,
  output logic [ebfc_pkg::MV_W-1:0]           out_millivolts,
  output logic                                out_lead_detached,
  output logic signed [ebfc_pkg::OUT_W-1:0]   out_filtered_value
);

  localparam int W      = STATE_WIDTH;
  localparam int ACC_W  = STATE_WIDTH + ebfc_pkg::ACC_GUARD;
  localparam int SEC_W  = (SECTION_COUNT > 1) ? $clog2(SECTION_COUNT) : 1;
  localparam int DROP   = ebfc_pkg::TABLE_FRAC - COEF_FRAC_BITS;
  localparam int OUT_W  = ebfc_pkg::OUT_W;
  localparam int MUL_W  = ebfc_pkg::MUL_W;
  localparam int PROD_W = ebfc_pkg::PROD_W;
  localparam int HALF_W = ebfc_pkg::HALF_W;
  localparam int EXT_W  = ebfc_pkg::OPND_EXT_W;
  localparam int MV_W   = ebfc_pkg::MV_W;
  localparam int RAW_W  = ebfc_pkg::RAW_W;
  localparam int MP_W   = ebfc_pkg::MV_PROD_W;

  // Clamp floor(v / 2^F) to the signed state width.
  function automatic logic signed [W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] sh;
    logic [ACC_W-W:0]        top;
    sh  = v >>> COEF_FRAC_BITS;
    top = sh[ACC_W-1:W-1];
    if ((&top) || (~|top)) begin
      return sh[W-1:0];
    end else if (top[ACC_W-W]) begin
      return {1'b1, {(W-1){1'b0}}};
    end else begin
      return {1'b0, {(W-1){1'b1}}};
    end
  endfunction

  // Drop the output fraction bits and clamp to the result width.
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [W-1:0] v);
    logic signed [W-1:0] sh;
    logic [W-OUT_W:0]    top;
    sh  = v >>> ebfc_pkg::OUT_FRAC_DROP;
    top = sh[W-1:OUT_W-1];
    if ((&top) || (~|top)) begin
      return sh[OUT_W-1:0];
    end else if (top[W-OUT_W]) begin
      return {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      return {1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

  // Sequencer control
  logic                          busy_r, busy_nxt;
  logic [ebfc_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic [SEC_W-1:0]              sec_r, sec_nxt;

  // Request payload held for the result
  logic [MV_W-1:0]               mv_r, mv_nxt;
  logic                          lo_r, lo_nxt;

  // Datapath
  logic signed [W-1:0]           x_r, x_nxt;
  logic signed [W-1:0]           y_r, y_nxt;
  logic signed [ACC_W-1:0]       acc_r, acc_nxt;
  logic signed [PROD_W-1:0]      prod_r, prod_nxt;
  logic                          prod_hi_r, prod_hi_nxt;
  logic signed [W-1:0]           s1_r [SECTION_COUNT];
  logic signed [W-1:0]           s1_nxt [SECTION_COUNT];
  logic signed [W-1:0]           s2_r [SECTION_COUNT];
  logic signed [W-1:0]           s2_nxt [SECTION_COUNT];

  // Output register
  logic                          out_req_valid_r, out_req_valid_nxt;
  logic [MV_W-1:0]               out_mv_r, out_mv_nxt;
  logic                          out_lo_r, out_lo_nxt;
  logic signed [OUT_W-1:0]       out_filt_r, out_filt_nxt;

  // Combinational helpers
  ebfc_pkg::uword_t                uw;
  logic [ebfc_pkg::TBL_IDX_W-1:0]  sec_tbl;
  logic signed [ebfc_pkg::COEF_W-1:0] coef_val;
  logic signed [W-1:0]             op_sel;
  logic signed [EXT_W-1:0]         op_ext;
  logic signed [MUL_W-1:0]         mul_a, mul_b;
  logic signed [PROD_W-1:0]        mul_p;
  logic signed [ACC_W-1:0]         prod_ext, prod_al;
  logic signed [W-1:0]             s1_cur, s2_cur, acc_sat;
  logic [MP_W-1:0]                 mv_prod;
  logic [MV_W-1:0]                 mv_hi, mv_lo;
  logic [MV_W:0]                   mv_t;
  logic [1:0]                      mv_corr;
  logic [MV_W-1:0]                 mv_calc;
  logic                            in_take, last_sec, out_free;

  // Fetch the control word and the coefficient of the current section.
  assign uw       = ebfc_pkg::ucode(step_r);
  assign sec_tbl  = ebfc_pkg::TBL_IDX_W'(sec_r);
  assign coef_val = ebfc_pkg::coef_lookup(sec_tbl, uw.coef, DROP);

  // Split the state-wide operand into an unsigned low half and a signed
  // high half so one 33x33 signed multiplier covers every product.
  assign op_sel = (uw.opnd == ebfc_pkg::OPND_Y) ? y_r : x_r;
  assign op_ext = EXT_W'(op_sel);
  assign mul_a  = MUL_W'(coef_val);
  assign mul_b  = uw.hi ? $signed({op_ext[EXT_W-1], op_ext[EXT_W-1:HALF_W]})
                        : $signed({1'b0, op_ext[HALF_W-1:0]});
  assign mul_p  = mul_a * mul_b;

  // Align the registered product to its weight.
  assign prod_ext = ACC_W'(prod_r);
  assign prod_al  = prod_hi_r ? (prod_ext <<< HALF_W) : prod_ext;

  assign s1_cur  = s1_r[sec_r];
  assign s2_cur  = s2_r[sec_r];
  assign acc_sat = sat_state(acc_r);

  // raw * 3100 = 4096 * hi + lo, so dividing by 4095 gives
  // hi + floor((hi + lo) / 4095), and hi + lo stays below 2 * 4096.
  assign mv_prod = MP_W'(in_raw_sample) * ebfc_pkg::MV_SCALE;
  assign mv_hi   = mv_prod[MP_W-1:RAW_W];
  assign mv_lo   = mv_prod[RAW_W-1:0];
  assign mv_t    = (MV_W+1)'(mv_hi) + (MV_W+1)'(mv_lo);
  assign mv_corr = (mv_t >= ebfc_pkg::DIV_TWO) ? 2'd2 :
                   (mv_t >= ebfc_pkg::DIV_ONE) ? 2'd1 : 2'd0;
  assign mv_calc = mv_hi + MV_W'(mv_corr);

  assign in_take  = in_valid && !busy_r;
  assign last_sec = (sec_r == SEC_W'(SECTION_COUNT - 1));
  assign out_free = !out_req_valid_r || !out_stall;

  always_comb begin
    busy_nxt          = busy_r;
    step_nxt          = step_r;
    sec_nxt           = sec_r;
    mv_nxt            = mv_r;
    lo_nxt            = lo_r;
    x_nxt             = x_r;
    y_nxt             = y_r;
    acc_nxt           = acc_r;
    prod_nxt          = prod_r;
    prod_hi_nxt       = prod_hi_r;
    s1_nxt            = s1_r;
    s2_nxt            = s2_r;
    out_req_valid_nxt = out_req_valid_r;
    out_mv_nxt        = out_mv_r;
    out_lo_nxt        = out_lo_r;
    out_filt_nxt      = out_filt_r;

    // Drop the result once the consumer takes it.
    if (out_req_valid_r && !out_stall) begin
      out_req_valid_nxt = 1'b0;
    end

    // Accept a request: scale to millivolts and load the first section input.
    if (in_take) begin
      busy_nxt = 1'b1;
      step_nxt = ebfc_pkg::STEP_FIRST;
      sec_nxt  = '0;
      mv_nxt   = mv_calc;
      lo_nxt   = in_lead_off_plus | in_lead_off_minus;
      x_nxt    = W'({mv_calc, {ebfc_pkg::SAMPLE_FRAC{1'b0}}});
    end

    if (busy_r) begin
      if (uw.mul_en) begin
        prod_nxt    = mul_p;
        prod_hi_nxt = uw.hi;
      end

      unique case (uw.acc)
        ebfc_pkg::ACC_HOLD:    acc_nxt = acc_r;
        ebfc_pkg::ACC_LOAD_S1: acc_nxt = ACC_W'(s1_cur) <<< COEF_FRAC_BITS;
        ebfc_pkg::ACC_LOAD_S2: acc_nxt = ACC_W'(s2_cur) <<< COEF_FRAC_BITS;
        ebfc_pkg::ACC_SET:     acc_nxt = prod_al;
        ebfc_pkg::ACC_ADD:     acc_nxt = acc_r + prod_al;
        ebfc_pkg::ACC_SUB:     acc_nxt = acc_r - prod_al;
        default:               acc_nxt = acc_r;
      endcase

      unique case (uw.wr)
        ebfc_pkg::WR_NONE: ;
        ebfc_pkg::WR_Y:    y_nxt = acc_sat;
        ebfc_pkg::WR_S1:   s1_nxt[sec_r] = acc_sat;
        ebfc_pkg::WR_S2:   s2_nxt[sec_r] = acc_sat;
      endcase

      unique case (uw.seq)
        ebfc_pkg::SEQ_NEXT: begin
          step_nxt = step_r + ebfc_pkg::STEP_W'(1);
        end
        ebfc_pkg::SEQ_SECTION: begin
          // The section output feeds the next section.
          x_nxt = y_r;
          if (last_sec) begin
            step_nxt = ebfc_pkg::STEP_FINISH;
          end else begin
            sec_nxt  = sec_r + SEC_W'(1);
            step_nxt = ebfc_pkg::STEP_FIRST;
          end
        end
        ebfc_pkg::SEQ_FINISH: begin
          // Hold here until the output register has room.
          if (out_free) begin
            out_req_valid_nxt = 1'b1;
            out_mv_nxt        = mv_r;
            out_lo_nxt        = lo_r;
            out_filt_nxt      = sat_out(y_r);
            busy_nxt          = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r          <= 1'b0;
      step_r          <= ebfc_pkg::STEP_FIRST;
      sec_r           <= '0;
      out_req_valid_r <= 1'b0;
      for (int i = 0; i < SECTION_COUNT; i++) begin
        s1_r[i] <= '0;
        s2_r[i] <= '0;
      end
    end else begin
      busy_r          <= busy_nxt;
      step_r          <= step_nxt;
      sec_r           <= sec_nxt;
      out_req_valid_r <= out_req_valid_nxt;
      s1_r            <= s1_nxt;
      s2_r            <= s2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mv_r       <= mv_nxt;
    lo_r       <= lo_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    acc_r      <= acc_nxt;
    prod_r     <= prod_nxt;
    prod_hi_r  <= prod_hi_nxt;
    out_mv_r   <= out_mv_nxt;
    out_lo_r   <= out_lo_nxt;
    out_filt_r <= out_filt_nxt;
  end

  assign in_stall           = busy_r;
  assign out_req_valid      = out_req_valid_r;
  assign out_millivolts     = out_mv_r;
  assign out_lead_detached  = out_lo_r;
  assign out_filtered_value = out_filt_r;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking bench for the ECG scaling, lead-off and biquad chain unit.
module testbench;

  // Fixed build of the unit: four sections, Q2.30 coefficients, 48-bit state.
  localparam int SECTIONS   = 4;
  localparam int FRAC_BITS  = 30;
  localparam int STATE_BITS = 48;
  localparam int MV_FRAC    = 16;
  localparam int Q8_DROP    = 8;

  // Busy span of one request: acceptance, 13 microprogram steps per section, finish step.
  localparam int CHAIN_CYCLES = 13 * SECTIONS + 2;

  localparam int DIRECTED_ROWS   = 22;
  localparam int RANDOM_REQUESTS = 930;
  localparam int IDLE_PERCENT    = 34;
  // Window of request counts during which neither side idles.
  localparam int CALM_FIRST = 300;
  localparam int CALM_LAST  = 500;

  typedef logic signed [127:0] wide_t;

  // b0, b1, b2, a1, a2 in signed Q2.30: high-pass, 50 Hz notch, 60 Hz notch, low-pass
  localparam logic signed [31:0] BIQUAD_COEF [SECTIONS][5] = '{
    '{ 32'sd1064243069, -32'sd2128486138, 32'sd1064243069,
      -32'sd2128402107,  32'sd1054828346 },
    '{ 32'sd1063325044, -32'sd1720496063, 32'sd1063325044,
      -32'sd1720496063,  32'sd1052908265 },
    '{ 32'sd1061629567, -32'sd1547789296, 32'sd1061629567,
      -32'sd1547789296,  32'sd1049517309 },
    '{ 32'sd21564350,    32'sd43128699,   32'sd21564350,
      -32'sd1676130396,  32'sd688645970 }
  };

  typedef struct packed {
    logic [ebfc_pkg::MV_W-1:0]         mv;
    logic                              off;
    logic signed [ebfc_pkg::OUT_W-1:0] fv;
  } result_t;

  // One stimulus row; typed rows carry millivolts and lead-off read straight
  // off the formula, and the filtered value only where the chain is known idle.
  typedef struct packed {
    logic [ebfc_pkg::RAW_W-1:0]        raw;
    logic                              plus;
    logic                              minus;
    logic                              typed;
    logic                              fv_known;
    logic [ebfc_pkg::MV_W-1:0]         mv;
    logic                              off;
    logic signed [ebfc_pkg::OUT_W-1:0] fv;
  } sample_row_t;

  // Directed rows: idle chain after reset with every lead-off combination,
  // full-scale steps, codes at the edges of the rounding, and a Nyquist-rate
  // square wave between the rails with the leads flapping (the filter keeps
  // running while the leads are off).
  localparam sample_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{12'd0,    1'b0, 1'b0, 1'b1, 1'b1, 12'd0,    1'b0, 22'sd0},
    '{12'd0,    1'b1, 1'b0, 1'b1, 1'b1, 12'd0,    1'b1, 22'sd0},
    '{12'd0,    1'b0, 1'b1, 1'b1, 1'b1, 12'd0,    1'b1, 22'sd0},
    '{12'd0,    1'b1, 1'b1, 1'b1, 1'b1, 12'd0,    1'b1, 22'sd0},
    '{12'd4095, 1'b0, 1'b0, 1'b1, 1'b0, 12'd3100, 1'b0, 22'sd0},
    '{12'd4095, 1'b0, 1'b0, 1'b1, 1'b0, 12'd3100, 1'b0, 22'sd0},
    '{12'd4095, 1'b1, 1'b1, 1'b1, 1'b0, 12'd3100, 1'b1, 22'sd0},
    '{12'd1,    1'b0, 1'b0, 1'b1, 1'b0, 12'd0,    1'b0, 22'sd0},
    '{12'd2,    1'b0, 1'b0, 1'b1, 1'b0, 12'd1,    1'b0, 22'sd0},
    '{12'd4094, 1'b0, 1'b0, 1'b1, 1'b0, 12'd3099, 1'b0, 22'sd0},
    '{12'd2048, 1'b0, 1'b0, 1'b1, 1'b0, 12'd1550, 1'b0, 22'sd0},
    '{12'd2047, 1'b0, 1'b0, 1'b1, 1'b0, 12'd1549, 1'b0, 22'sd0},
    '{12'd1321, 1'b0, 1'b0, 1'b1, 1'b0, 12'd1000, 1'b0, 22'sd0},
    '{12'd3072, 1'b0, 1'b0, 1'b1, 1'b0, 12'd2325, 1'b0, 22'sd0},
    '{12'd0,    1'b1, 1'b0, 1'b1, 1'b0, 12'd0,    1'b1, 22'sd0},
    '{12'd4095, 1'b0, 1'b1, 1'b1, 1'b0, 12'd3100, 1'b1, 22'sd0},
    '{12'd0,    1'b0, 1'b0, 1'b1, 1'b0, 12'd0,    1'b0, 22'sd0},
    '{12'd4095, 1'b1, 1'b1, 1'b1, 1'b0, 12'd3100, 1'b1, 22'sd0},
    '{12'd0,    1'b0, 1'b0, 1'b1, 1'b0, 12'd0,    1'b0, 22'sd0},
    '{12'd4095, 1'b0, 1'b0, 1'b1, 1'b0, 12'd3100, 1'b0, 22'sd0},
    '{12'd0,    1'b0, 1'b0, 1'b1, 1'b0, 12'd0,    1'b0, 22'sd0},
    '{12'd4095, 1'b0, 1'b0, 1'b1, 1'b0, 12'd3100, 1'b0, 22'sd0}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                          in_valid          = 1'b0;
  logic                          in_stall;
  logic [ebfc_pkg::RAW_W-1:0]    in_raw_sample     = '0;
  logic                          in_lead_off_plus  = 1'b0;
  logic                          in_lead_off_minus = 1'b0;
  logic                          out_req_valid;
  logic                          out_stall         = 1'b0;
  logic [ebfc_pkg::MV_W-1:0]     out_millivolts;
  logic                          out_lead_detached;
  logic signed [ebfc_pkg::OUT_W-1:0] out_filtered_value;

  // Predictor state: the two delay registers of every section, Q.16.
  wide_t sec_z1 [SECTIONS];
  wide_t sec_z2 [SECTIONS];

  result_t pending_results [$];
  result_t oldest_result;
  int      mismatch_count = 0;
  int      requests_sent  = 0;
  int      results_seen   = 0;

  always #2 clk = ~clk;

  ecg_biquad_filter_chain_unit u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_raw_sample      (in_raw_sample),
    .in_lead_off_plus   (in_lead_off_plus),
    .in_lead_off_minus  (in_lead_off_minus),
    .out_req_valid      (out_req_valid),
    .out_stall          (out_stall),
    .out_millivolts     (out_millivolts),
    .out_lead_detached  (out_lead_detached),
    .out_filtered_value (out_filtered_value)
  );

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Clamp to a signed field of the given width.
  function automatic wide_t clamp_to(input wide_t v, input int w);
    wide_t top;
    wide_t bot;
    top = 1;
    top = (top <<< (w - 1)) - 1;
    bot = -top - 1;
    if (v > top) return top;
    if (v < bot) return bot;
    return v;
  endfunction

  // Scale one sample to millivolts and push it through the four sections,
  // advancing the predictor's delay registers.
  function automatic result_t condition_sample(input logic [ebfc_pkg::RAW_W-1:0] raw,
                                               input logic plus, input logic minus);
    result_t r;
    wide_t   c [5];
    wide_t   x;
    wide_t   y;
    wide_t   next_z1;
    wide_t   next_z2;
    r.mv  = ebfc_pkg::MV_W'((32'(raw) * 32'd3100) / 32'd4095);
    r.off = plus | minus;
    x = 0;
    x[ebfc_pkg::MV_W-1+MV_FRAC:MV_FRAC] = r.mv;
    for (int s = 0; s < SECTIONS; s++) begin
      for (int k = 0; k < 5; k++) c[k] = wide_t'(BIQUAD_COEF[s][k]);
      y = clamp_to((c[0] * x + (sec_z1[s] <<< FRAC_BITS)) >>> FRAC_BITS, STATE_BITS);
      next_z1 = clamp_to((c[1] * x - c[3] * y + (sec_z2[s] <<< FRAC_BITS)) >>> FRAC_BITS,
                         STATE_BITS);
      next_z2 = clamp_to((c[2] * x - c[4] * y) >>> FRAC_BITS, STATE_BITS);
      sec_z1[s] = next_z1;
      sec_z2[s] = next_z2;
      x = y;
    end
    y = clamp_to(x >>> Q8_DROP, ebfc_pkg::OUT_W);
    r.fv = y[ebfc_pkg::OUT_W-1:0];
    return r;
  endfunction

  // Offer one request, idling at random beforehand, hold it until the unit
  // takes it, then queue what it should produce.
  task automatic send_request(input sample_row_t row);
    result_t predicted;
    while (!(requests_sent >= CALM_FIRST && requests_sent < CALM_LAST) &&
           $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_raw_sample     <= row.raw;
    in_lead_off_plus  <= row.plus;
    in_lead_off_minus <= row.minus;
    // Values read right after the edge are the ones the unit sampled.
    do @(posedge clk); while (in_stall);
    predicted = condition_sample(row.raw, row.plus, row.minus);
    if (row.typed) begin
      predicted.mv  = row.mv;
      predicted.off = row.off;
      if (row.fv_known) predicted.fv = row.fv;
    end
    pending_results.push_back(predicted);
    requests_sent++;
  endtask

  // Stimulus: reset, directed rows, then a random ECG-like trace.
  initial begin
    sample_row_t row;
    int          level;
    int          pick;
    for (int s = 0; s < SECTIONS; s++) begin
      sec_z1[s] = 0;
      sec_z2[s] = 0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++) send_request(DIRECTED[i]);

    // Mostly a slowly wandering baseline with beat-like jumps, so the
    // high-pass and notch states build up; the rest is uniform noise and
    // rail hits.
    level = 2048;
    row   = '0;
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        level = level + $urandom_range(0, 192) - 96;
      end else if (pick < 75) begin
        level = level + $urandom_range(0, 3000) - 1500;
      end else if (pick < 90) begin
        level = $urandom_range(0, 4095);
      end else begin
        level = $urandom_range(0, 1) ? 4095 : 0;
      end
      if (level < 0) level = 0;
      if (level > 4095) level = 4095;
      row.raw = level[ebfc_pkg::RAW_W-1:0];
      if ($urandom_range(0, 7) == 0) begin
        row.plus  = 1'($urandom_range(0, 1));
        row.minus = 1'($urandom_range(0, 1));
      end else begin
        row.plus  = 1'b0;
        row.minus = 1'b0;
      end
      send_request(row);
    end
    in_valid <= 1'b0;

    // Drain, then watch a while longer for stray results.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * CHAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Result side: check each accepted result against the oldest prediction,
  // then decide the stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_req_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result with no request pending: mv %0d off %0d fv %0d",
                                out_millivolts, out_lead_detached, out_filtered_value));
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_millivolts !== oldest_result.mv)
          flag_mismatch($sformatf("result %0d millivolts %0d, want %0d",
                                  results_seen, out_millivolts, oldest_result.mv));
        if (out_lead_detached !== oldest_result.off)
          flag_mismatch($sformatf("result %0d lead_detached %0d, want %0d",
                                  results_seen, out_lead_detached, oldest_result.off));
        if (out_filtered_value !== oldest_result.fv)
          flag_mismatch($sformatf("result %0d filtered_value %0d, want %0d",
                                  results_seen, out_filtered_value, oldest_result.fv));
      end
      results_seen++;
    end
    // Hold off at random, except in the calm window.
    if (results_seen >= CALM_FIRST && results_seen < CALM_LAST) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ebfc_pkg.sv
hw/rtl/ecg_biquad_filter_chain_unit.sv
tb/testbench.sv
